[rtl/grtt_pkg.sv]
// ---------------------------------------------------------------------------
// grtt_pkg: shared types and constants for the grid ray tile tracer
// Holds command codes, result codes and the controller/datapath interface.
// ---------------------------------------------------------------------------
package grtt_pkg;

    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_CLEAR = 2'd1;
    localparam logic [1:0] CMD_TRACE = 2'd2;
    localparam logic [1:0] CMD_READ  = 2'd3;

    localparam logic [1:0] ST_ACK  = 2'd0;
    localparam logic [1:0] ST_WALL = 2'd1;
    localparam logic [1:0] ST_DOOR = 2'd2;
    localparam logic [1:0] ST_LEFT = 2'd3;

    // The tile ports are six bits wide, so the map side is fixed.
    localparam int MAP_SIZE = 64;

    localparam int POS_W  = 22;
    localparam int WORD_W = 10;
    localparam int ACC_W  = 34;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start;     // capture the transfer and set up the walk
        logic clr_step;  // write one visibility entry to zero (sweep)
        logic vprobe;    // probe the current vertical-walk tile (read issued)
        logic hprobe;    // probe the current horizontal-walk tile (read issued)
        logic vresolve;  // evaluate tile data for a vertical probe
        logic hresolve;  // evaluate tile data for a horizontal probe
        logic finish;    // form the result
    } grtt_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic v_pending;  // vertical walk still has a boundary to cross
        logic h_pending;
        logic v_inmap;
        logic h_inmap;
        logic hit;        // last resolve stopped the ray
        logic clr_last;   // sweep has reached the final entry
    } grtt_stat_t;

endpackage

[rtl/grtt_ram.sv]
// ---------------------------------------------------------------------------
// grtt_ram: generic single-port RAM with registered read
// One write or one read per cycle; read data appears in the following cycle.
// ---------------------------------------------------------------------------
module grtt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

[rtl/grtt_datapath.sv]
// ---------------------------------------------------------------------------
// grtt_datapath: walk registers, tile and visibility stores, hit logic
// Carries out the commands of the controller one step at a time.
// ---------------------------------------------------------------------------
module grtt_datapath #(
    parameter int FRAC_BITS = 16,
    parameter int DOOR_FULL = 63
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  grtt_pkg::grtt_cmd_t  cmd_in,
    output grtt_pkg::grtt_stat_t stat,
    input  logic [1:0]           cmd,
    input  logic [5:0]           tile_x,
    input  logic [5:0]           tile_y,
    input  logic [9:0]           tile_word,
    input  logic [21:0]          ray_x,
    input  logic [21:0]          ray_y,
    input  logic [1:0]           quadrant,
    input  logic signed [31:0]   step_x,
    input  logic signed [31:0]   step_y,
    input  logic signed [31:0]   intercept_x,
    input  logic signed [31:0]   intercept_y,
    output logic [1:0]           res_status,
    output logic [21:0]          res_hit_x,
    output logic [21:0]          res_hit_y,
    output logic                 res_hit_vertical,
    output logic                 res_visible
);
    import grtt_pkg::*;

    localparam int MB    = $clog2(MAP_SIZE);
    localparam int AW    = 2 * MB;
    localparam int DEPTH = MAP_SIZE * MAP_SIZE;
    localparam int TW    = ACC_W - FRAC_BITS + 1;  // signed tile coordinate width
    localparam int DSH   = FRAC_BITS - 6;
    localparam logic signed [ACC_W-1:0] ONE  = ACC_W'(1) <<< FRAC_BITS;
    localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) <<< (FRAC_BITS - 1);

    // Captured item.
    logic [1:0]              cmd_reg;
    logic [5:0]              tx_reg, ty_reg;
    logic [POS_W-1:0]        px_reg, py_reg;
    logic                    xneg_reg, yneg_reg;
    logic signed [ACC_W-1:0] xstep_reg, ystep_reg;
    // Walk registers.
    logic signed [TW-1:0]    xtile_reg, ytile_reg;
    logic signed [ACC_W-1:0] xint_reg, yint_reg;
    logic [1:0]              status_reg;
    logic [POS_W-1:0]        hx_reg, hy_reg;
    logic                    hv_reg;
    logic                    hit_reg;
    logic [AW-1:0]           clr_reg;
    logic [AW-1:0]           paddr_reg;

    logic signed [TW-1:0] ymap, xmap;
    assign ymap = TW'(yint_reg >>> FRAC_BITS);
    assign xmap = TW'(xint_reg >>> FRAC_BITS);

    function automatic logic in_map(input logic signed [TW-1:0] t);
        return (t >= 0) && (t < TW'(MAP_SIZE));
    endfunction

    assign stat.v_pending = yneg_reg ? (ymap > ytile_reg) : (ymap < ytile_reg);
    assign stat.h_pending = xneg_reg ? (xmap > xtile_reg) : (xmap < xtile_reg);
    assign stat.v_inmap   = in_map(xtile_reg) && in_map(ymap);
    assign stat.h_inmap   = in_map(ytile_reg) && in_map(xmap);
    assign stat.hit       = hit_reg;
    assign stat.clr_last  = (clr_reg == AW'(DEPTH - 1));

    // Memory ports.
    logic              tm_we, vm_we;
    logic [AW-1:0]     tm_addr, vm_addr;
    logic [WORD_W-1:0] tm_rd;
    logic [0:0]        vm_rd, vm_wd;
    logic [AW-1:0]     vaddr, haddr, in_addr, start_addr;
    logic              in_ok, start_ok;
    logic signed [TW-1:0] sx0, sy0;

    assign in_ok   = (32'(tile_x) < MAP_SIZE) && (32'(tile_y) < MAP_SIZE);
    assign in_addr = {tile_x[MB-1:0], tile_y[MB-1:0]};
    assign vaddr   = {xtile_reg[MB-1:0], ymap[MB-1:0]};
    assign haddr   = {xmap[MB-1:0], ytile_reg[MB-1:0]};
    assign sx0     = TW'(px_reg >> FRAC_BITS);
    assign sy0     = TW'(py_reg >> FRAC_BITS);
    assign start_ok   = in_map(sx0) && in_map(sy0);
    assign start_addr = {sx0[MB-1:0], sy0[MB-1:0]};

    // Door and wall evaluation for the tile data now on the read port.
    logic                    vert, flip;
    logic signed [ACC_W-1:0] frac, dfrac, cross_frac;
    logic signed [TW-1:0]    ptx, pty;
    logic [5:0]              amt, opened;
    logic [1:0]              dstate;
    logic                    wall, door_block;
    logic [POS_W-1:0]        rhx, rhy;

    function automatic logic [POS_W-1:0] pos_of(input logic signed [TW-1:0] t,
                                                  input logic signed [ACC_W-1:0] f);
        logic signed [ACC_W-1:0] v;
        v = (ACC_W'(t) <<< FRAC_BITS) + f;
        return v[POS_W-1:0];
    endfunction

    always_comb
    begin
        vert   = cmd_in.vresolve;
        flip   = vert ? xneg_reg : yneg_reg;
        frac   = vert ? (yint_reg & (ONE - 1)) : (xint_reg & (ONE - 1));
        dfrac  = vert ? ystep_reg : xstep_reg;
        ptx    = vert ? xtile_reg : xmap;
        pty    = vert ? ymap : ytile_reg;
        cross_frac = frac + (dfrac >>> 1);
        amt    = 6'(cross_frac >>> DSH);
        opened = tm_rd[9:4];
        dstate = tm_rd[3:2];
        wall   = tm_rd[0];
        door_block = 1'b0;
        if (tm_rd[1] && dstate != 2'd0 && cross_frac >= 0 && cross_frac < ONE)
        begin
            if (dstate == 2'd1)
                door_block = 1'b1;
            else if (vert)
                door_block = !(32'(amt) > DOOR_FULL - 32'(opened));
            else
                door_block = !(amt < opened);
        end
        if (wall)
        begin
            rhx = vert ? pos_of(ptx, flip ? ONE : '0) : pos_of(ptx, frac);
            rhy = vert ? pos_of(pty, frac) : pos_of(pty, flip ? ONE : '0);
        end
        else
        begin
            rhx = vert ? pos_of(ptx, HALF) : pos_of(ptx, cross_frac);
            rhy = vert ? pos_of(pty, cross_frac) : pos_of(pty, HALF);
        end
    end

    always_comb
    begin
        tm_we   = 1'b0;
        tm_addr = in_addr;
        vm_we   = 1'b0;
        vm_addr = in_addr;
        vm_wd   = 1'b1;
        if (cmd_in.start)
        begin
            tm_we = (cmd == CMD_LOAD) && in_ok;
        end
        else if (cmd_in.clr_step)
        begin
            vm_we   = 1'b1;
            vm_addr = clr_reg;
            vm_wd   = 1'b0;
        end
        else if (cmd_in.vprobe || cmd_in.hprobe)
        begin
            tm_addr = cmd_in.vprobe ? vaddr : haddr;
        end
        else if ((cmd_in.vresolve || cmd_in.hresolve) && !wall)
        begin
            vm_we   = 1'b1;
            vm_addr = paddr_reg;
        end
        else if (cmd_in.finish && cmd_reg == CMD_TRACE)
        begin
            vm_we   = start_ok;
            vm_addr = start_addr;
        end
        else
        begin
            vm_addr = {tx_reg[MB-1:0], ty_reg[MB-1:0]};
        end
    end

    grtt_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_tile_ram (
        .clk(clk), .we(tm_we), .addr(tm_addr), .wdata(tile_word), .rdata(tm_rd)
    );

    grtt_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_vis_ram (
        .clk(clk), .we(vm_we), .addr(vm_addr), .wdata(vm_wd), .rdata(vm_rd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg    <= '0;
            hit_reg    <= 1'b0;
            status_reg <= ST_ACK;
            xtile_reg  <= '0;
            ytile_reg  <= '0;
            xint_reg   <= '0;
            yint_reg   <= '0;
        end
        else
        begin
            if (cmd_in.start)
            begin
                hit_reg    <= 1'b0;
                status_reg <= (cmd == CMD_TRACE) ? ST_LEFT : ST_ACK;
                xtile_reg  <= TW'(ray_x >> FRAC_BITS) + ((quadrant == 2'd1 || quadrant == 2'd2)
                              ? -TW'(1) : TW'(1));
                ytile_reg  <= TW'(ray_y >> FRAC_BITS) + (quadrant[1] ? -TW'(1) : TW'(1));
                xint_reg   <= ACC_W'(intercept_x);
                yint_reg   <= ACC_W'(intercept_y);
                clr_reg    <= '0;
            end
            if (cmd_in.clr_step)
                clr_reg <= clr_reg + 1'b1;
            if (cmd_in.vresolve || cmd_in.hresolve)
            begin
                if (wall || door_block)
                begin
                    hit_reg    <= 1'b1;
                    status_reg <= wall ? ST_WALL : ST_DOOR;
                end
                else if (cmd_in.vresolve)
                begin
                    xtile_reg <= xtile_reg + (xneg_reg ? -TW'(1) : TW'(1));
                    yint_reg  <= yint_reg + ystep_reg;
                end
                else
                begin
                    ytile_reg <= ytile_reg + (yneg_reg ? -TW'(1) : TW'(1));
                    xint_reg  <= xint_reg + xstep_reg;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_in.start)
        begin
            cmd_reg   <= cmd;
            tx_reg    <= tile_x;
            ty_reg    <= tile_y;
            px_reg    <= ray_x;
            py_reg    <= ray_y;
            xneg_reg  <= (quadrant == 2'd1 || quadrant == 2'd2);
            yneg_reg  <= quadrant[1];
            xstep_reg <= ACC_W'(step_x);
            ystep_reg <= ACC_W'(step_y);
        end
        if (cmd_in.vprobe)
            paddr_reg <= vaddr;
        if (cmd_in.hprobe)
            paddr_reg <= haddr;
        if ((cmd_in.vresolve || cmd_in.hresolve) && (wall || door_block))
        begin
            hx_reg <= rhx;
            hy_reg <= rhy;
            hv_reg <= cmd_in.vresolve;
        end
        if (cmd_in.finish)
        begin
            res_status       <= status_reg;
            res_hit_x        <= '0;
            res_hit_y        <= '0;
            res_hit_vertical <= 1'b0;
            res_visible      <= 1'b0;
            if (cmd_reg == CMD_TRACE)
            begin
                res_hit_x <= (status_reg == ST_LEFT) ? px_reg : hx_reg;
                res_hit_y <= (status_reg == ST_LEFT) ? py_reg : hy_reg;
                res_hit_vertical <= (status_reg == ST_LEFT) ? 1'b0 : hv_reg;
            end
            else if (cmd_reg == CMD_READ)
            begin
                res_visible <= vm_rd[0] && (32'(tx_reg) < MAP_SIZE) && (32'(ty_reg) < MAP_SIZE);
            end
        end
    end

endmodule

[rtl/grtt_ctrl.sv]
// ---------------------------------------------------------------------------
// grtt_ctrl: sequencing state machine for the ray tile tracer
// Runs the command flow and the alternating vertical/horizontal walks.
// ---------------------------------------------------------------------------
module grtt_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           cmd,
    output logic                 out_valid,
    input  logic                 out_ready,
    output grtt_pkg::grtt_cmd_t  cmd_out,
    input  grtt_pkg::grtt_stat_t stat
);
    import grtt_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_CLEAR, S_VTEST, S_VREAD, S_VRES, S_HTEST, S_HREAD,
        S_HRES, S_FIN, S_READ, S_OUT
    } state_t;

    state_t state_reg;
    logic   moved_reg;
    logic   init_reg;
    logic [1:0] cmd_reg;

    assign in_ready  = (state_reg == S_IDLE) || (state_reg == S_OUT && out_ready);
    assign out_valid = (state_reg == S_OUT);

    always_comb
    begin
        cmd_out          = '0;
        cmd_out.start    = in_valid && in_ready;
        cmd_out.clr_step = (state_reg == S_CLEAR);
        cmd_out.vprobe   = (state_reg == S_VREAD);
        cmd_out.hprobe   = (state_reg == S_HREAD);
        cmd_out.vresolve = (state_reg == S_VRES);
        cmd_out.hresolve = (state_reg == S_HRES);
        cmd_out.finish   = (state_reg == S_FIN);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            // The visibility bitmap is swept clear after reset; no result.
            state_reg <= S_CLEAR;
            moved_reg <= 1'b0;
            init_reg  <= 1'b1;
            cmd_reg   <= CMD_LOAD;
        end
        else
        begin
            case (state_reg)
                S_IDLE, S_OUT:
                begin
                    if (state_reg == S_OUT && !out_ready)
                        state_reg <= S_OUT;
                    else if (in_valid)
                    begin
                        cmd_reg   <= cmd;
                        state_reg <= S_DECODE;
                    end
                    else
                        state_reg <= S_IDLE;
                end
                S_DECODE:
                begin
                    moved_reg <= 1'b0;
                    case (cmd_reg)
                        CMD_CLEAR: state_reg <= S_CLEAR;
                        CMD_TRACE: state_reg <= S_VTEST;
                        CMD_READ:  state_reg <= S_READ;
                        default:   state_reg <= S_FIN;
                    endcase
                end
                S_CLEAR:
                    if (stat.clr_last)
                    begin
                        init_reg  <= 1'b0;
                        state_reg <= init_reg ? S_IDLE : S_FIN;
                    end
                S_READ:
                    state_reg <= S_FIN;
                S_VTEST:
                begin
                    if (!stat.v_pending)
                        state_reg <= S_HTEST;
                    else if (!stat.v_inmap)
                        state_reg <= S_FIN;
                    else
                        state_reg <= S_VREAD;
                end
                S_VREAD:
                    state_reg <= S_VRES;
                S_VRES:
                begin
                    moved_reg <= 1'b1;
                    state_reg <= S_VTEST;
                end
                S_HTEST:
                begin
                    if (stat.hit)
                        state_reg <= S_FIN;
                    else if (!stat.h_pending)
                    begin
                        moved_reg <= 1'b0;
                        state_reg <= moved_reg ? S_VTEST : S_FIN;
                    end
                    else if (!stat.h_inmap)
                        state_reg <= S_FIN;
                    else
                        state_reg <= S_HREAD;
                end
                S_HREAD:
                    state_reg <= S_HRES;
                S_HRES:
                begin
                    moved_reg <= 1'b1;
                    state_reg <= S_HTEST;
                end
                S_FIN:
                    state_reg <= S_OUT;
                default:
                    state_reg <= S_IDLE;
            endcase
            if (state_reg == S_VTEST && stat.hit)
                state_reg <= S_FIN;
        end
    end

endmodule

[rtl/grid_ray_tile_tracer.sv]
// ---------------------------------------------------------------------------
// grid_ray_tile_tracer: tile-map ray walker for a grid raycaster
// Top level joining the sequencing controller and the walk datapath.
// ---------------------------------------------------------------------------
// The block takes one transfer at a time and returns exactly one result
// transfer for it. After reset the block first sweeps its visibility bitmap
// to zero, one entry a cycle, and holds in_ready low until the sweep ends.
// A load passes through the decode and finish states before it raises
// out_valid, and a visibility read passes through a read state as well.
// Clearing the bitmap sweeps all MAP_SIZE*MAP_SIZE entries of its
// single-port RAM, one entry a cycle, before its result is formed.
// Each step of a trace tests the walk, reads the tile RAM through its
// registered port and then resolves the hit; every switch between the
// vertical and the horizontal walk adds another test. A ray across the
// default map crosses up to about 128 tiles. The start tile is marked
// visible as the trace finishes.
// The tile map has no reset: every tile must be loaded before a trace
// touches it.
module grid_ray_tile_tracer #(
    parameter int FRAC_BITS = 16,
    parameter int DOOR_FULL = 63
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         cmd,
    input  logic [5:0]         tile_x,
    input  logic [5:0]         tile_y,
    input  logic [9:0]         tile_word,
    input  logic [21:0]        ray_x,
    input  logic [21:0]        ray_y,
    input  logic [1:0]         quadrant,
    input  logic signed [31:0] step_x,
    input  logic signed [31:0] step_y,
    input  logic signed [31:0] intercept_x,
    input  logic signed [31:0] intercept_y,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         status,
    output logic [21:0]        hit_x,
    output logic [21:0]        hit_y,
    output logic               hit_vertical,
    output logic               visible
);
    import grtt_pkg::*;

    grtt_cmd_t  ctl_cmd;
    grtt_stat_t dp_stat;

    grtt_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .cmd(cmd), .out_valid(out_valid), .out_ready(out_ready),
        .cmd_out(ctl_cmd), .stat(dp_stat)
    );

    grtt_datapath #(.FRAC_BITS(FRAC_BITS), .DOOR_FULL(DOOR_FULL)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd_in(ctl_cmd), .stat(dp_stat),
        .cmd(cmd), .tile_x(tile_x), .tile_y(tile_y), .tile_word(tile_word),
        .ray_x(ray_x), .ray_y(ray_y), .quadrant(quadrant),
        .step_x(step_x), .step_y(step_y),
        .intercept_x(intercept_x), .intercept_y(intercept_y),
        .res_status(status), .res_hit_x(hit_x), .res_hit_y(hit_y),
        .res_hit_vertical(hit_vertical), .res_visible(visible)
    );

endmodule

[verif/grid_ray_tile_tracer_test.sv]
// ---------------------------------------------------------------------------
// grid_ray_tile_tracer_test: self-checking testbench for the ray tile tracer
// Loads a random map of walls, doors and open floor, then sends directed
// and random commands. A scoreboard with its own copy of the tile map and
// visibility bitmap predicts every result and compares it field by field.
// ---------------------------------------------------------------------------
module grid_ray_tile_tracer_test;
    import grtt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  MAP       = 64;
    localparam int  FRAC      = 16;
    localparam int  DOOR_OPEN = 63;
    localparam longint ONE    = 64'sd1 <<< FRAC;
    localparam longint LIMIT  = 10_000_000;

    // One command as it appears on the input channel.
    typedef struct {
        logic [1:0]         op;
        logic [5:0]         tx;
        logic [5:0]         ty;
        logic [9:0]         word;
        logic [21:0]        rx;
        logic [21:0]        ry;
        logic [1:0]         quad;
        logic signed [31:0] sx;
        logic signed [31:0] sy;
        logic signed [31:0] ix;
        logic signed [31:0] iy;
    } tracer_cmd_t;

    // One expected result.
    typedef struct {
        logic [1:0]  st;
        logic [21:0] hx;
        logic [21:0] hy;
        logic        hv;
        logic        vis;
    } tracer_res_t;

    // The scoreboard keeps its own tile map and visibility bitmap, works out
    // the result of every accepted transfer and checks what the block sends.
    class tracer_scoreboard;
        logic [9:0]  tiles [MAP*MAP];
        bit          seen [MAP*MAP];
        tracer_res_t pending [$];
        int          errors;
        int          outcome_count [4];
        int          results;

        function new();
            errors = 0;
            results = 0;
            foreach (seen[i]) seen[i] = 1'b0;
            foreach (tiles[i]) tiles[i] = '0;
            foreach (outcome_count[i]) outcome_count[i] = 0;
        endfunction

        function logic [21:0] position(longint t, longint frac);
            longint p;
            p = t * ONE + frac;
            return p[21:0];
        endfunction

        function bit on_map(longint t);
            return t >= 0 && t < MAP;
        endfunction

        // Tests one tile on the walk; 0 to go on, else the stopping status.
        function int probe_tile(longint tx, longint ty, longint frac, longint dfrac,
                                bit vert, bit flip, output tracer_res_t r);
            int     idx;
            logic [9:0] w;
            longint amt;
            idx = int'(tx) * MAP + int'(ty);
            w = tiles[idx];
            r = '{default: '0};
            if (w[0])
            begin
                if (vert)
                begin
                    r.hx = position(tx, flip ? ONE : 0);
                    r.hy = position(ty, frac);
                end
                else
                begin
                    r.hx = position(tx, frac);
                    r.hy = position(ty, flip ? ONE : 0);
                end
                r.hv = vert;
                return ST_WALL;
            end
            seen[idx] = 1'b1;
            if (!w[1] || w[3:2] == 2'd0)
                return 0;
            // The door is tested where the ray crosses the tile's middle line.
            frac = frac + (dfrac >>> 1);
            if (frac < 0 || frac >= ONE)
                return 0;
            amt = frac >>> (FRAC - 6);
            if (vert)
            begin
                if (w[3:2] != 2'd1 && amt > DOOR_OPEN - longint'(w[9:4]))
                    return 0;
                r.hx = position(tx, ONE / 2);
                r.hy = position(ty, frac);
                r.hv = 1'b1;
            end
            else
            begin
                if (w[3:2] != 2'd1 && amt < longint'(w[9:4]))
                    return 0;
                r.hx = position(tx, frac);
                r.hy = position(ty, ONE / 2);
                r.hv = 1'b0;
            end
            return ST_DOOR;
        endfunction

        function tracer_res_t walk_ray(tracer_cmd_t c);
            tracer_res_t r;
            longint xs, ys, px, py, xstep, ystep, xint, yint;
            longint xtile, ytile, xmap, ymap;
            int     st;
            bit     moved;
            bit     stop;
            xs = (c.quad == 2'd0 || c.quad == 2'd3) ? 1 : -1;
            ys = (c.quad <= 2'd1) ? 1 : -1;
            px = longint'(c.rx);
            py = longint'(c.ry);
            xstep = longint'(c.sx);
            ystep = longint'(c.sy);
            xint = longint'(c.ix);
            yint = longint'(c.iy);
            xtile = (px >>> FRAC) + xs;
            ytile = (py >>> FRAC) + ys;
            ymap = yint >>> FRAC;
            xmap = xint >>> FRAC;
            r = '{default: '0};
            st = ST_LEFT;
            stop = 1'b0;
            if (on_map(px >>> FRAC) && on_map(py >>> FRAC))
                seen[int'(px >>> FRAC) * MAP + int'(py >>> FRAC)] = 1'b1;
            while (!stop)
            begin
                moved = 1'b0;
                // Walk across vertical grid lines, then horizontal ones.
                while (!stop && !(ys == -1 && ymap <= ytile) && !(ys == 1 && ymap >= ytile))
                begin
                    if (!on_map(xtile) || !on_map(ymap))
                        stop = 1'b1;
                    else
                    begin
                        st = probe_tile(xtile, ymap, yint & (ONE - 1), ystep, 1'b1,
                                        xs == -1, r);
                        if (st != 0)
                            stop = 1'b1;
                        else
                        begin
                            st = ST_LEFT;
                            xtile += xs;
                            yint += ystep;
                            ymap = yint >>> FRAC;
                            moved = 1'b1;
                        end
                    end
                end
                while (!stop && !(xs == -1 && xmap <= xtile) && !(xs == 1 && xmap >= xtile))
                begin
                    if (!on_map(ytile) || !on_map(xmap))
                        stop = 1'b1;
                    else
                    begin
                        st = probe_tile(xmap, ytile, xint & (ONE - 1), xstep, 1'b0,
                                        ys == -1, r);
                        if (st != 0)
                            stop = 1'b1;
                        else
                        begin
                            st = ST_LEFT;
                            ytile += ys;
                            xint += xstep;
                            xmap = xint >>> FRAC;
                            moved = 1'b1;
                        end
                    end
                end
                // A pass with no step can never advance: the ray has left.
                if (!moved)
                    stop = 1'b1;
            end
            if (st == ST_LEFT)
            begin
                r.hx = c.rx;
                r.hy = c.ry;
                r.hv = 1'b0;
            end
            r.st = st[1:0];
            r.vis = 1'b0;
            return r;
        endfunction

        function void note_transfer(tracer_cmd_t c);
            tracer_res_t r;
            int idx;
            r = '{default: '0};
            idx = int'(c.tx) * MAP + int'(c.ty);
            case (c.op)
                CMD_LOAD:  tiles[idx] = c.word;
                CMD_CLEAR: foreach (seen[i]) seen[i] = 1'b0;
                CMD_TRACE: r = walk_ray(c);
                default:   r.vis = seen[idx];
            endcase
            if (c.op == CMD_TRACE)
                outcome_count[r.st]++;
            pending.push_back(r);
        endfunction

        function void check_result(tracer_res_t got);
            tracer_res_t exp;
            results++;
            if (pending.size() == 0)
            begin
                $error("result transfer with nothing expected");
                errors++;
                return;
            end
            exp = pending.pop_front();
            if (got.st !== exp.st)
            begin
                $error("status: expected %0d, got %0d", exp.st, got.st);
                errors++;
            end
            if (got.hx !== exp.hx)
            begin
                $error("hit_x: expected %0h, got %0h", exp.hx, got.hx);
                errors++;
            end
            if (got.hy !== exp.hy)
            begin
                $error("hit_y: expected %0h, got %0h", exp.hy, got.hy);
                errors++;
            end
            if (got.hv !== exp.hv)
            begin
                $error("hit_vertical: expected %0d, got %0d", exp.hv, got.hv);
                errors++;
            end
            if (got.vis !== exp.vis)
            begin
                $error("visible: expected %0d, got %0d", exp.vis, got.vis);
                errors++;
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [1:0]         cmd;
    logic [5:0]         tile_x;
    logic [5:0]         tile_y;
    logic [9:0]         tile_word;
    logic [21:0]        ray_x;
    logic [21:0]        ray_y;
    logic [1:0]         quadrant;
    logic signed [31:0] step_x;
    logic signed [31:0] step_y;
    logic signed [31:0] intercept_x;
    logic signed [31:0] intercept_y;
    logic               out_valid;
    logic               out_ready;
    logic [1:0]         status;
    logic [21:0]        hit_x;
    logic [21:0]        hit_y;
    logic               hit_vertical;
    logic               visible;

    tracer_scoreboard sb;
    longint           cycle_count;
    int               burst_left;

    grid_ray_tile_tracer uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .cmd          (cmd),
        .tile_x       (tile_x),
        .tile_y       (tile_y),
        .tile_word    (tile_word),
        .ray_x        (ray_x),
        .ray_y        (ray_y),
        .quadrant     (quadrant),
        .step_x       (step_x),
        .step_y       (step_y),
        .intercept_x  (intercept_x),
        .intercept_y  (intercept_y),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .hit_x        (hit_x),
        .hit_y        (hit_y),
        .hit_vertical (hit_vertical),
        .visible      (visible)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Result side. The ready pattern changes character in equal stretches:
    // a stretch of no stalls, a stretch of coin-flip stalls, and a stretch
    // of occasional stalls.
    initial
    begin
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
                sb.check_result('{status, hit_x, hit_y, hit_vertical, visible});
            case ((cycle_count / 512) % 3)
                0:       out_ready <= 1'b1;
                1:       out_ready <= $urandom_range(0, 1);
                default: out_ready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // Drives one command and holds it until the transfer happens. Between
    // bursts of random length the sender drops valid for a random gap.
    task automatic send_cmd(tracer_cmd_t c);
        in_valid    <= 1'b1;
        cmd         <= c.op;
        tile_x      <= c.tx;
        tile_y      <= c.ty;
        tile_word   <= c.word;
        ray_x       <= c.rx;
        ray_y       <= c.ry;
        quadrant    <= c.quad;
        step_x      <= c.sx;
        step_y      <= c.sy;
        intercept_x <= c.ix;
        intercept_y <= c.iy;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_transfer(c);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6))
                @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
        end
    endtask

    function automatic tracer_cmd_t blank_cmd(logic [1:0] op);
        tracer_cmd_t c;
        c = '{default: '0};
        c.op = op;
        c.rx = 22'($urandom());
        c.ry = 22'($urandom());
        c.quad = 2'($urandom());
        c.sx = $urandom();
        c.sy = $urandom();
        c.ix = $urandom();
        c.iy = $urandom();
        return c;
    endfunction

    // A random tile: some walls, some doors, the rest open floor whose
    // unused bits are still random.
    function automatic logic [9:0] random_tile();
        logic [9:0] w;
        int         pick;
        w = 10'($urandom());
        pick = $urandom_range(0, 99);
        if (pick < 9)
            w[0] = 1'b1;
        else if (pick < 20)
            w[1:0] = 2'b10;
        else
            w[1:0] = 2'b00;
        return w;
    endfunction

    task automatic load_tile(int x, int y, logic [9:0] w);
        tracer_cmd_t c;
        c = blank_cmd(CMD_LOAD);
        c.tx = 6'(x);
        c.ty = 6'(y);
        c.word = w;
        send_cmd(c);
    endtask

    task automatic read_tile(int x, int y);
        tracer_cmd_t c;
        c = blank_cmd(CMD_READ);
        c.tx = 6'(x);
        c.ty = 6'(y);
        send_cmd(c);
    endtask

    // A ray whose steps and intercepts agree with its quadrant, as a host
    // would compute them; about one in ten is pure noise instead.
    task automatic trace_ray(bit noisy);
        tracer_cmd_t c;
        longint xs, ys;
        c = blank_cmd(CMD_TRACE);
        if (!noisy)
        begin
            xs = (c.quad == 2'd0 || c.quad == 2'd3) ? 1 : -1;
            ys = (c.quad <= 2'd1) ? 1 : -1;
            c.sx = 32'(xs * longint'($urandom_range(0, 4 * ONE)));
            c.sy = 32'(ys * longint'($urandom_range(0, 4 * ONE)));
            c.ix = 32'(longint'(c.rx) + xs * longint'($urandom_range(0, ONE)));
            c.iy = 32'(longint'(c.ry) + ys * longint'($urandom_range(0, ONE)));
        end
        send_cmd(c);
    endtask

    task automatic trace_fixed(logic [21:0] rx, logic [21:0] ry, logic [1:0] q,
                               longint sx, longint sy, longint ix, longint iy);
        tracer_cmd_t c;
        c = blank_cmd(CMD_TRACE);
        c.rx = rx;
        c.ry = ry;
        c.quad = q;
        c.sx = 32'(sx);
        c.sy = 32'(sy);
        c.ix = 32'(ix);
        c.iy = 32'(iy);
        send_cmd(c);
    endtask

    initial
    begin
        int          pick;
        int          n;
        sb = new();
        cycle_count = 0;
        burst_left = 0;
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        cmd <= CMD_LOAD;
        tile_x <= '0;
        tile_y <= '0;
        tile_word <= '0;
        ray_x <= '0;
        ray_y <= '0;
        quadrant <= '0;
        step_x <= '0;
        step_y <= '0;
        intercept_x <= '0;
        intercept_y <= '0;
        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The tile map has no reset, so every tile is loaded before any
        // trace can touch it. The visibility bitmap starts with a clear.
        for (int x = 0; x < MAP; x++)
            for (int y = 0; y < MAP; y++)
                load_tile(x, y, random_tile());
        send_cmd(blank_cmd(CMD_CLEAR));

        // Directed part: extreme tile words, each door state, corner reads,
        // rays in every quadrant, a ray that cannot advance, a clear, a noise ray.
        load_tile(63, 63, 10'h3FF);
        load_tile(0, 0, 10'h000);
        load_tile(32, 33, 10'b111111_01_1_0);
        load_tile(33, 32, 10'b000000_00_1_0);
        load_tile(31, 32, 10'b100000_10_1_0);
        load_tile(32, 31, 10'b011111_11_1_0);
        read_tile(63, 63);
        read_tile(0, 0);
        for (int q = 0; q < 4; q++)
            trace_fixed(22'h208000, 22'h208000, 2'(q),
                        (q == 0 || q == 3) ? ONE / 3 : -ONE / 3,
                        (q <= 1) ? ONE / 2 : -ONE / 2,
                        (q == 0 || q == 3) ? 33 * ONE + 100 : 32 * ONE - 100,
                        (q <= 1) ? 33 * ONE + 7 : 32 * ONE - 7);
        trace_fixed(22'h208000, 22'h208000, 2'd0, 0, 0, 0, 0);
        trace_fixed(22'h3FFFFF, 22'h3FFFFF, 2'd0, 1, 1, 64 * ONE, 64 * ONE);
        trace_fixed(22'h000000, 22'h000000, 2'd2, -ONE, -ONE, -1, -1);
        trace_fixed(22'h3FFFFF, 22'h000000, 2'd1, 32'sh7FFFFFFF, 32'sh80000000,
                    32'sh80000000, 32'sh7FFFFFFF);
        read_tile(32, 32);
        read_tile(32, 33);
        send_cmd(blank_cmd(CMD_CLEAR));
        read_tile(32, 32);
        trace_ray(1'b1);
        trace_ray(1'b0);

        // Random part: mostly well-formed rays, with reads, map updates,
        // a few clears and a share of noise rays.
        for (n = 0; n < 2000; n++)
        begin
            pick = $urandom_range(0, 999);
            if (pick < 8)
                send_cmd(blank_cmd(CMD_CLEAR));
            else if (pick < 140)
                load_tile($urandom_range(0, MAP - 1), $urandom_range(0, MAP - 1),
                          random_tile());
            else if (pick < 300)
                read_tile($urandom_range(0, MAP - 1), $urandom_range(0, MAP - 1));
            else
                trace_ray($urandom_range(0, 9) == 0);
        end
        in_valid <= 1'b0;

        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (50)
            @(posedge clk);

        $display("covered %0d results: %0d wall hits, %0d door hits, %0d rays left the map",
                 sb.results, sb.outcome_count[ST_WALL], sb.outcome_count[ST_DOOR],
                 sb.outcome_count[ST_LEFT]);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

[filelist.f]
rtl/grtt_pkg.sv
rtl/grtt_ram.sv
rtl/grtt_datapath.sv
rtl/grtt_ctrl.sv
rtl/grid_ray_tile_tracer.sv
verif/grid_ray_tile_tracer_test.sv
